// ----- hdl/utf8_codepoint_decoder_unit_defines.svh -----
// assertion macros for the decoder rtl top level
`ifndef UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define UCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ucd_pkg.sv -----
// types, constants and lead byte classification for the utf-8 decoder
`default_nettype none

package ucd_pkg;

  typedef logic [7:0]  text_byte_t;
  typedef logic [20:0] codepoint_t;

  localparam text_byte_t ASCII_LIMIT = 8'h80;
  localparam text_byte_t TWO_MASK    = 8'hE0;
  localparam text_byte_t TWO_LEAD    = 8'hC0;
  localparam text_byte_t THREE_MASK  = 8'hF0;
  localparam text_byte_t THREE_LEAD  = 8'hE0;
  localparam text_byte_t FOUR_MASK   = 8'hF8;
  localparam text_byte_t FOUR_LEAD   = 8'hF0;

  // result queue between decode and output, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    LEAD_ONE,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_SKIP
  } lead_kind_t;

  // results of one request: cp0 always valid, cp1 valid when two is set
  typedef struct packed {
    codepoint_t cp0;
    codepoint_t cp1;
    logic       two;
  } job_t;

  function automatic lead_kind_t lead_kind(input text_byte_t b);
    lead_kind_t k;
    if (b < ASCII_LIMIT) begin
      k = LEAD_ONE;
    end else if ((b & TWO_MASK) == TWO_LEAD) begin
      k = LEAD_TWO;
    end else if ((b & THREE_MASK) == THREE_LEAD) begin
      k = LEAD_THREE;
    end else if ((b & FOUR_MASK) == FOUR_LEAD) begin
      k = LEAD_FOUR;
    end else begin
      k = LEAD_SKIP;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ucd_if.sv -----
// valid/ready channel interfaces for the byte input and codepoint output
`default_nettype none

interface ucd_in_if;
  import ucd_pkg::*;

  logic       valid;
  logic       ready;
  text_byte_t text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ucd_out_if;
  import ucd_pkg::*;

  logic       valid;
  logic       ready;
  codepoint_t codepoint;
  logic       run_end;

  modport source (output valid, output codepoint, output run_end, input ready);
  modport sink   (input valid, input codepoint, input run_end, output ready);
endinterface

`default_nettype wire

// ----- hdl/utf8_codepoint_decoder_unit.sv -----
// utf-8 decoder top level: byte input, codepoint output
// Takes one text byte per request and returns decoded codepoints, run_end set
// on the last codepoint a byte produces. A byte is accepted every cycle while
// the two-entry job queue has room; the front end decodes it in the cycle it
// is accepted. The output register sends one codepoint per cycle while the
// receiver is ready, so a byte that yields two codepoints (a text that ends
// inside a sequence) fills it twice. Each codepoint passes through the job
// queue and output register. Bytes that produce nothing never enter the queue.
`default_nettype none

`include "utf8_codepoint_decoder_unit_defines.svh"

module utf8_codepoint_decoder_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ucd_in_if.sink    in_ch,
  ucd_out_if.source out_ch
);
  import ucd_pkg::*;

  logic push;
  logic q_ready;
  logic q_valid;
  logic pop;
  job_t wr_job;
  job_t rd_job;

  ucd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (push),
    .job     (wr_job)
  );

  ucd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_job  (wr_job),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_job  (rd_job)
  );

  ucd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .rd_job  (rd_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  `UCD_ASSERT_SAME(a_no_zero_cp, out_ch.valid, out_ch.codepoint != '0, "zero codepoint sent")
  `UCD_ASSERT_NEXT(a_pair_follows, out_ch.valid && !out_ch.run_end, out_ch.valid, "second codepoint missing")
  `UCD_ASSERT_SAME(a_pair_queued, out_ch.valid && !out_ch.run_end, q_valid, "job popped before its second codepoint")

endmodule

`default_nettype wire

// ----- hdl/ucd_front.sv -----
// front end: accepts bytes, tracks the open sequence and forms result jobs
`default_nettype none

module ucd_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ucd_in_if.sink           in_ch,
  input  wire logic        q_ready,
  output logic             push,
  output ucd_pkg::job_t    job
);
  import ucd_pkg::*;

  text_byte_t held0_r, held1_r, held2_r;
  text_byte_t held0_nxt, held1_nxt, held2_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] need_r, need_nxt;

  text_byte_t b;
  logic       fin;
  logic       accept;
  lead_kind_t kind;
  lead_kind_t k0;
  lead_kind_t k1;
  text_byte_t t0;
  logic       two_tail;
  codepoint_t seq;
  codepoint_t pair;
  codepoint_t cpa, cpb;
  logic       va, vb;
  logic [1:0] extra;

  assign b           = in_ch.text_byte;
  assign fin         = in_ch.final_byte;
  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  assign kind     = lead_kind(b);
  assign two_tail = (cnt_r >= 2'd2);
  assign t0       = two_tail ? held1_r : b;
  assign k0       = lead_kind(t0);
  assign k1       = kind;
  assign pair     = {10'b0, t0[4:0], b[5:0]};

  always_comb begin
    unique case (kind)
      LEAD_TWO:   extra = 2'd1;
      LEAD_THREE: extra = 2'd2;
      LEAD_FOUR:  extra = 2'd3;
      default:    extra = 2'd0;
    endcase
  end

  // whole sequence from held lead and continuations plus current byte
  always_comb begin
    unique case (cnt_r)
      2'd1:    seq = {10'b0, held0_r[4:0], b[5:0]};
      2'd2:    seq = {5'b0, held0_r[3:0], held1_r[5:0], b[5:0]};
      2'd3:    seq = {held0_r[2:0], held1_r[5:0], held2_r[5:0], b[5:0]};
      default: seq = '0;
    endcase
  end

  always_comb begin
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    held2_nxt = held2_r;
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    cpa       = '0;
    cpb       = '0;
    va        = 1'b0;
    vb        = 1'b0;
    if (need_r == 2'd0 || cnt_r == 2'd0) begin
      held0_nxt = '0;
      held1_nxt = '0;
      held2_nxt = '0;
      cnt_nxt   = '0;
      need_nxt  = '0;
      if (kind == LEAD_ONE) begin
        cpa = {13'b0, b};
        va  = (b != '0);
      end else if (kind != LEAD_SKIP && !fin) begin
        held0_nxt = b;
        cnt_nxt   = 2'd1;
        need_nxt  = extra;
      end
    end else if (need_r == 2'd1) begin
      cpa       = seq;
      va        = (seq != '0);
      held0_nxt = '0;
      held1_nxt = '0;
      held2_nxt = '0;
      cnt_nxt   = '0;
      need_nxt  = '0;
    end else if (fin || cnt_r == 2'd3) begin
      // text ends inside a sequence: lead dropped, rest decoded as leads
      if (!two_tail) begin
        cpa = {13'b0, b};
        va  = (k1 == LEAD_ONE) && (b != '0);
      end else if (k0 == LEAD_ONE) begin
        cpa = {13'b0, t0};
        va  = (t0 != '0);
        cpb = {13'b0, b};
        vb  = (k1 == LEAD_ONE) && (b != '0);
      end else if (k0 == LEAD_TWO) begin
        cpa = pair;
        va  = (pair != '0);
      end else begin
        cpb = {13'b0, b};
        vb  = (k1 == LEAD_ONE) && (b != '0);
      end
      held0_nxt = '0;
      held1_nxt = '0;
      held2_nxt = '0;
      cnt_nxt   = '0;
      need_nxt  = '0;
    end else begin
      if (cnt_r == 2'd1) begin
        held1_nxt = b;
      end else begin
        held2_nxt = b;
      end
      cnt_nxt  = cnt_r + 2'd1;
      need_nxt = need_r - 2'd1;
    end
    if (fin) begin
      held0_nxt = '0;
      held1_nxt = '0;
      held2_nxt = '0;
      cnt_nxt   = '0;
      need_nxt  = '0;
    end
  end

  assign job.cp0 = va ? cpa : cpb;
  assign job.cp1 = cpb;
  assign job.two = va && vb;
  assign push    = accept && (va || vb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r <= '0;
      held1_r <= '0;
      held2_r <= '0;
      cnt_r   <= '0;
      need_r  <= '0;
    end else if (accept) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
      cnt_r   <= cnt_nxt;
      need_r  <= need_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ucd_queue.sv -----
// small job queue between the front end and the output sequencer
`default_nettype none

module ucd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ucd_pkg::job_t wr_job,
  output logic               q_ready,
  input  wire logic          pop,
  output logic               q_valid,
  output ucd_pkg::job_t      rd_job
);
  import ucd_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_job  = mem_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ucd_back.sv -----
// back end: sends the one or two codepoints of each job through the output register
`default_nettype none

module ucd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire ucd_pkg::job_t rd_job,
  output logic               pop,
  ucd_out_if.source          out_ch
);
  import ucd_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  codepoint_t cp_r, cp_nxt;
  logic       run_end_r, run_end_nxt;
  logic       phase_r, phase_nxt;
  logic       load;

  assign load = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cp_nxt        = cp_r;
    run_end_nxt   = run_end_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!phase_r) begin
        cp_nxt      = rd_job.cp0;
        run_end_nxt = !rd_job.two;
        phase_nxt   = rd_job.two;
        pop         = !rd_job.two;
      end else begin
        cp_nxt      = rd_job.cp1;
        run_end_nxt = 1'b1;
        phase_nxt   = 1'b0;
        pop         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_r      <= cp_nxt;
    run_end_r <= run_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.codepoint = cp_r;
  assign out_ch.run_end   = run_end_r;

endmodule

`default_nettype wire

// ----- bench/ucd_checker.sv -----
// checker for the utf-8 decoder: predicts codepoints per byte request and compares results
module ucd_checker (
  input  logic clk,
  input  logic rst_n,
  ucd_in_if    in_ch,
  ucd_out_if   out_ch,
  output int   mismatch_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ucd_pkg::*;

  typedef struct packed {
    codepoint_t codepoint;
    logic       run_end;
  } decoded_cp_t;

  decoded_cp_t pending_codepoints[$];
  decoded_cp_t want_cp;

  text_byte_t  held_bytes [3];
  logic [1:0]  held_count;
  logic [1:0]  bytes_needed;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic clear_held();
    held_bytes[0] = '0;
    held_bytes[1] = '0;
    held_bytes[2] = '0;
    held_count    = '0;
    bytes_needed  = '0;
  endtask

  // continuation bytes a lead takes, 4 for a byte that is skipped
  function automatic int trail_count(input text_byte_t b);
    if (b < ASCII_LIMIT) return 0;
    if ((b & 8'hE0) == 8'hC0) return 1;
    if ((b & 8'hF0) == 8'hE0) return 2;
    if ((b & 8'hF8) == 8'hF0) return 3;
    return 4;
  endfunction

  function automatic codepoint_t merge_seq(input text_byte_t seq [4], input int len);
    int unsigned acc;
    if (len == 2) begin
      acc = seq[0] & 8'h1F;
    end else if (len == 3) begin
      acc = seq[0] & 8'h0F;
    end else begin
      acc = seq[0] & 8'h07;
    end
    for (int i = 1; i < len; i++) begin
      acc = (acc << 6) | (seq[i] & 8'h3F);
    end
    return codepoint_t'(acc);
  endfunction

  task automatic push_codepoint(input codepoint_t cp, inout int n);
    decoded_cp_t item;
    if (cp != '0 && n < 2) begin
      item.codepoint = cp;
      item.run_end   = 1'b0;
      pending_codepoints.insert(pending_codepoints.size(), item);
      n++;
    end
  endtask

  task automatic decode_request(input text_byte_t b, input logic fin);
    text_byte_t seq [4];
    text_byte_t tail [2];
    int k;
    int n;
    int cnt;
    int tlen;
    int pos;
    n   = 0;
    cnt = int'(held_count);
    if (bytes_needed == 2'd0 || held_count == 2'd0) begin
      k = trail_count(b);
      clear_held();
      if (k == 0) begin
        push_codepoint(codepoint_t'(b), n);
      end else if (k <= 3 && !fin) begin
        held_bytes[0] = b;
        held_count    = 2'd1;
        bytes_needed  = 2'(k);
      end
    end else if (bytes_needed == 2'd1) begin
      seq = '{default: 8'h00};
      for (int i = 0; i < cnt; i++) begin
        seq[i] = held_bytes[i];
      end
      seq[cnt] = b;
      push_codepoint(merge_seq(seq, cnt + 1), n);
      clear_held();
    end else if (fin || cnt >= 3) begin
      // text ends inside a sequence: drop the lead, decode what followed it
      tlen = 0;
      if (cnt > 1) begin
        tail[0] = held_bytes[1];
        tlen    = 1;
      end
      tail[tlen] = b;
      tlen++;
      pos = 0;
      while (pos < tlen) begin
        k = trail_count(tail[pos]);
        if (k == 0) begin
          push_codepoint(codepoint_t'(tail[pos]), n);
          pos++;
        end else if (k == 1 && pos + 1 < tlen) begin
          seq    = '{default: 8'h00};
          seq[0] = tail[pos];
          seq[1] = tail[pos + 1];
          push_codepoint(merge_seq(seq, 2), n);
          pos += 2;
        end else begin
          pos++;
        end
      end
      clear_held();
    end else begin
      held_bytes[cnt] = b;
      held_count      = held_count + 2'd1;
      bytes_needed    = bytes_needed - 2'd1;
    end
    if (fin) begin
      clear_held();
    end
    if (n > 0) begin
      pending_codepoints[pending_codepoints.size() - 1].run_end = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_held();
      pending_codepoints.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_request(in_ch.text_byte, in_ch.final_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_codepoints.size() == 0) begin
          report_mismatch($sformatf("unexpected codepoint %h run_end %b",
                                    out_ch.codepoint, out_ch.run_end));
        end else begin
          want_cp = pending_codepoints.pop_front();
          if (out_ch.codepoint !== want_cp.codepoint) begin
            report_mismatch($sformatf("codepoint %h, predicted %h",
                                      out_ch.codepoint, want_cp.codepoint));
          end
          if (out_ch.run_end !== want_cp.run_end) begin
            report_mismatch($sformatf("run_end %b, predicted %b for codepoint %h",
                                      out_ch.run_end, want_cp.run_end, want_cp.codepoint));
          end
        end
      end
    end
    outstanding = pending_codepoints.size();
  end

endmodule

// ----- bench/tb_utf8_codepoint_decoder_unit.sv -----
// testbench top for the utf-8 decoder: byte text stimulus, receiver stalls and verdict
module tb_utf8_codepoint_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ucd_pkg::*;

  localparam int TEXT_BYTES = 1850;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   outstanding;
  bit   quiet;
  int   bytes_sent;

  ucd_in_if  in_ch ();
  ucd_out_if out_ch ();

  utf8_codepoint_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ucd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic send_byte(input text_byte_t b, input logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.text_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic drain_pause();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_bytes(ref text_byte_t bytes[$]);
    for (int i = 0; i < bytes.size(); i++) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  function automatic text_byte_t trail_byte();
    if ($urandom_range(0, 7) == 0) return text_byte_t'($urandom_range(0, 255));
    return 8'h80 | text_byte_t'($urandom_range(0, 63));
  endfunction

  // byte after a cut-off lead: ascii, a two-byte lead, a trail or anything
  function automatic text_byte_t cut_byte();
    case ($urandom_range(0, 3))
      0: return text_byte_t'($urandom_range(0, 127));
      1: return 8'hC0 | text_byte_t'($urandom_range(0, 31));
      2: return 8'h80 | text_byte_t'($urandom_range(0, 63));
      default: return text_byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_text(input int nchars, input bit cut_short);
    text_byte_t bytes[$];
    int extra;
    for (int c = 0; c < nchars; c++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          bytes.insert(bytes.size(), text_byte_t'($urandom_range(0, 127)));
          extra = 0;
        end
        4, 5: begin
          bytes.insert(bytes.size(), 8'hC0 | text_byte_t'($urandom_range(0, 31)));
          extra = 1;
        end
        6, 7: begin
          bytes.insert(bytes.size(), 8'hE0 | text_byte_t'($urandom_range(0, 15)));
          extra = 2;
        end
        default: begin
          bytes.insert(bytes.size(), 8'hF0 | text_byte_t'($urandom_range(0, 7)));
          extra = 3;
        end
      endcase
      repeat (extra) bytes.insert(bytes.size(), trail_byte());
    end
    if (cut_short) begin
      if ($urandom_range(0, 1) == 0) begin
        bytes.insert(bytes.size(), 8'hF0 | text_byte_t'($urandom_range(0, 7)));
        extra = $urandom_range(0, 2);
      end else begin
        bytes.insert(bytes.size(), 8'hE0 | text_byte_t'($urandom_range(0, 15)));
        extra = $urandom_range(0, 1);
      end
      repeat (extra) bytes.insert(bytes.size(), cut_byte());
    end
    send_bytes(bytes);
  endtask

  task automatic send_noise(input int len);
    text_byte_t bytes[$];
    repeat (len) bytes.insert(bytes.size(), text_byte_t'($urandom_range(0, 255)));
    send_bytes(bytes);
  endtask

  task automatic drive_receiver();
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  endtask

  initial begin
    text_byte_t directed[$];
    bit         directed_fin[$];
    int         pick;
    int         text_no;
    in_ch.valid      = 1'b0;
    in_ch.text_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    quiet            = 1'b0;
    bytes_sent       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    fork
      drive_receiver();
    join_none

    // zero byte, ascii top, two, three and four byte forms, largest codepoint
    directed = '{8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                 // skipped leads, overlong zero, lead as last byte
                 8'h80, 8'hFF, 8'hC0, 8'h80, 8'hE2,
                 // texts cut short: two results, a merged pair, a lone byte
                 8'hF0, 8'h41, 8'h42, 8'hF0, 8'hC3, 8'hA9, 8'hE2, 8'h41, 8'h41};
    directed_fin = '{0, 0, 0, 0, 0, 0, 0,
                     0, 0, 0, 0,
                     0, 0, 0, 0, 1,
                     0, 0, 1, 0, 0, 1, 0, 1, 1};
    for (int i = 0; i < directed.size(); i++) begin
      send_byte(directed[i], directed_fin[i]);
    end
    drain_pause();

    text_no = 0;
    while (bytes_sent < TEXT_BYTES) begin
      quiet = ($urandom_range(0, 5) == 0);
      pick  = $urandom_range(0, 9);
      if (pick == 0) begin
        send_noise($urandom_range(1, 10));
      end else if (pick <= 2) begin
        send_text($urandom_range(0, 6), 1'b1);
      end else begin
        send_text($urandom_range(1, 10), 1'b0);
      end
      text_no++;
      if (text_no % 60 == 0) begin
        drain_pause();
      end
    end
    quiet = 1'b0;

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
